>>> rtl/bsa_pkg.sv
// Shared types and codes for the deadlock-avoiding resource allocator.
// No dependencies; every other file of the block imports this package.
package bsa_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD_FREE = 2'd0,
    MODE_LOAD_PAIR = 2'd1,
    MODE_REQUEST   = 2'd2,
    MODE_CHECK     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STS_LOADED     = 3'd0,
    STS_REJECTED   = 3'd1,
    STS_GRANTED    = 3'd2,
    STS_EXCEEDS    = 3'd3,
    STS_WAIT       = 3'd4,
    STS_ROLLED_BACK = 3'd5,
    STS_SAFE       = 3'd6,
    STS_UNSAFE     = 3'd7
  } status_t;

  // Write commands from the sequencer to the resource tables.
  typedef struct packed {
    logic load_free;
    logic load_pair;
    logic grant;
    logic undo;
  } store_cmd_t;

  localparam int SEQ_SLOTS = 5;
  localparam int SLOT_BITS = 3;

endpackage

>>> rtl/bsa_store.sv
// Resource tables: free units per resource, held units and remaining need per
// (process, resource) pair, with one row read port. Depends on bsa_pkg.
module bsa_store #(
  parameter int NP = 5,
  parameter int NR = 3,
  parameter int CW = 8,
  parameter int PID_W = 3,
  parameter int RID_W = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bsa_pkg::store_cmd_t      cmd,
  input  logic [PID_W-1:0]         pid,
  input  logic [RID_W-1:0]         rid,
  input  logic [CW-1:0]            wr_value,
  input  logic [CW-1:0]            wr_need,
  input  logic [NR-1:0][CW-1:0]    req,
  output logic [NR-1:0][CW-1:0]    free_vec,
  output logic [NR-1:0][CW-1:0]    held_row,
  output logic [NR-1:0][CW-1:0]    need_row
);
  import bsa_pkg::*;

  logic [NR-1:0][CW-1:0] free_u;
  logic [NR-1:0][CW-1:0] held_a [NP];
  logic [NR-1:0][CW-1:0] need_a [NP];

  assign free_vec = free_u;
  assign held_row = held_a[pid];
  assign need_row = need_a[pid];

  always_ff @(posedge clk) begin
    if (rst) begin
      free_u <= '0;
      for (int p = 0; p < NP; p++) begin
        held_a[p] <= '0;
        need_a[p] <= '0;
      end
    end else begin
      if (cmd.load_free) begin
        free_u[rid] <= wr_value;
      end
      if (cmd.load_pair) begin
        held_a[pid][rid] <= wr_value;
        need_a[pid][rid] <= wr_need;
      end
      // A grant moves units from free and need into held; undo moves them back.
      if (cmd.grant) begin
        for (int r = 0; r < NR; r++) begin
          free_u[r]      <= free_u[r] - req[r];
          held_a[pid][r] <= held_a[pid][r] + req[r];
          need_a[pid][r] <= need_a[pid][r] - req[r];
        end
      end
      if (cmd.undo) begin
        for (int r = 0; r < NR; r++) begin
          free_u[r]      <= free_u[r] + req[r];
          held_a[pid][r] <= held_a[pid][r] - req[r];
          need_a[pid][r] <= need_a[pid][r] + req[r];
        end
      end
    end
  end

endmodule

>>> rtl/bsa_scan_unit.sv
// Safety scan engine: one compare-and-accumulate step per cycle over the
// process rows, repeated in passes until all finish or a pass adds none.
// Depends on bsa_pkg.
module bsa_scan_unit #(
  parameter int NP = 5,
  parameter int NR = 3,
  parameter int CW = 8,
  parameter int PID_W = 3
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [NR-1:0][CW-1:0]    free_vec,
  input  logic [NR-1:0][CW-1:0]    need_row,
  input  logic [NR-1:0][CW-1:0]    held_row,
  output logic [PID_W-1:0]         rd_pid,
  output logic                     running,
  output logic                     fin,
  output logic                     safe,
  output logic [2:0]               placed,
  output logic [14:0]              order
);
  import bsa_pkg::*;

  localparam int N_W = $clog2(NP + 1);
  localparam int WORK_W = CW + $clog2(NP + 1);

  logic [NR-1:0][WORK_W-1:0] work;
  logic [NR-1:0][WORK_W-1:0] work_sum;
  logic [NP-1:0]             done_mask;
  logic [N_W-1:0]            n;
  logic [N_W-1:0]            n_next;
  logic [14:0]               seq;
  logic [14:0]               seq_next;
  logic [PID_W-1:0]          pidx;
  logic                      prog;
  logic                      prog_next;
  logic                      fits;
  logic                      last;
  logic                      all_done;
  logic                      finish;

  assign rd_pid = pidx;

  always_comb begin
    fits = !done_mask[pidx];
    for (int r = 0; r < NR; r++) begin
      if (WORK_W'(need_row[r]) > work[r]) begin
        fits = 1'b0;
      end
      work_sum[r] = work[r] + WORK_W'(held_row[r]);
    end
    n_next = fits ? n + 1'b1 : n;
    seq_next = seq;
    if (fits) begin
      for (int s = 0; s < SEQ_SLOTS; s++) begin
        if (4'(n) == 4'(s)) begin
          seq_next[SLOT_BITS*s +: SLOT_BITS] = 3'(pidx);
        end
      end
    end
    prog_next = prog | fits;
    last      = (pidx == PID_W'(NP - 1));
    all_done  = (n_next == N_W'(NP));
    // The scan ends once every process is placed, or when a full pass placed none.
    finish    = all_done || (last && !prog_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        running   <= 1'b1;
        for (int r = 0; r < NR; r++) begin
          work[r] <= WORK_W'(free_vec[r]);
        end
        done_mask <= '0;
        n         <= '0;
        seq       <= '0;
        pidx      <= '0;
        prog      <= 1'b0;
      end else if (running) begin
        if (fits) begin
          work            <= work_sum;
          done_mask[pidx] <= 1'b1;
        end
        n   <= n_next;
        seq <= seq_next;
        if (finish) begin
          running <= 1'b0;
          fin     <= 1'b1;
          safe    <= all_done;
          placed  <= (4'(n_next) > 4'd7) ? 3'd7 : 3'(n_next);
          order   <= seq_next;
        end else if (last) begin
          pidx <= '0;
          prog <= 1'b0;
        end else begin
          pidx <= pidx + 1'b1;
          prog <= prog_next;
        end
      end
    end
  end

endmodule

>>> rtl/bankers_safety_allocator_top.sv
// Top level of the deadlock-avoiding resource allocator: command sequencer,
// resource tables and safety scan engine. Depends on bsa_pkg, bsa_store and
// bsa_scan_unit.
//
//   channel   handshake          payload
//   --------  -----------------  ----------------------------------------------
//   command   start, busy        mode, process_id, resource_id, amount, claim,
//                                request_a, request_b, request_c
//   result    done (one cycle)   status, safe_count, safe_sequence
//
// A command transfers when start is high and busy is low; busy then stays high
// until the result strobe. Loads and rejected requests answer from the execute
// state after the transfer; a check then scans, and a request grants, scans and
// rolls back if unsafe. A scan covers one process row per cycle, in
// NUM_PROCESSES to NUM_PROCESSES * NUM_PROCESSES steps. The receiver cannot
// stall; a result is shown for exactly one cycle. Reset clears all tables.
module bankers_safety_allocator_top #(
  parameter int NUM_PROCESSES = 5,
  parameter int NUM_RESOURCES = 3,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  mode,
  input  logic [2:0]  process_id,
  input  logic [1:0]  resource_id,
  input  logic [7:0]  amount,
  input  logic [7:0]  claim,
  input  logic [7:0]  request_a,
  input  logic [7:0]  request_b,
  input  logic [7:0]  request_c,
  output logic        busy,
  output logic        done,
  output logic [2:0]  status,
  output logic [2:0]  safe_count,
  output logic [14:0] safe_sequence
);
  import bsa_pkg::*;

  localparam int NP = NUM_PROCESSES;
  localparam int NR = NUM_RESOURCES;
  localparam int CW = COUNT_BITS;
  localparam int PID_W = $clog2(NP);
  localparam int RID_W = (NR > 1) ? $clog2(NR) : 1;
  localparam int EXT_W = (CW > 8) ? CW : 8;
  localparam logic [2:0] FULL_COUNT = 3'((NP > 7) ? 7 : NP);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GRANT,
    ST_SCAN_GO,
    ST_SCAN_WAIT,
    ST_ROLLBACK
  } state_t;

  state_t state;

  mode_t      mode_q;
  logic [2:0] process_id_q;
  logic [1:0] resource_id_q;
  logic [7:0] amount_q;
  logic [7:0] claim_q;
  logic [7:0] request_a_q;
  logic [7:0] request_b_q;
  logic [7:0] request_c_q;

  store_cmd_t            store_cmd;
  logic [PID_W-1:0]      rd_pid;
  logic [NR-1:0][CW-1:0] free_vec;
  logic [NR-1:0][CW-1:0] held_row;
  logic [NR-1:0][CW-1:0] need_row;
  logic [NR-1:0][CW-1:0] req_vec;
  logic [NR-1:0][7:0]    req_lane;

  logic [PID_W-1:0] scan_pid;
  logic             scan_running;
  logic             scan_fin;
  logic             scan_safe;
  logic [2:0]       scan_placed;
  logic [14:0]      scan_order;

  logic    pid_ok;
  logic    rid_ok;
  logic    free_ok;
  logic    pair_ok;
  logic    req_hit;
  status_t req_status;

  assign busy = (state != ST_IDLE);

  // Process and resource range checks, width checks and request screening.
  always_comb begin
    pid_ok  = ({1'b0, process_id_q} < 4'(NP));
    rid_ok  = ({1'b0, resource_id_q} < 3'(NR));
    free_ok = rid_ok && ((amount_q >> CW) == 8'd0);
    pair_ok = rid_ok && pid_ok && ((amount_q >> CW) == 8'd0) &&
              ((claim_q >> CW) == 8'd0) && (amount_q <= claim_q);
    for (int r = 0; r < NR; r++) begin
      if (r == 0) begin
        req_lane[r] = request_a_q;
      end else if (r == 1) begin
        req_lane[r] = request_b_q;
      end else if (r == 2) begin
        req_lane[r] = request_c_q;
      end else begin
        req_lane[r] = 8'd0;
      end
      req_vec[r] = CW'(req_lane[r]);
    end
    // Resources are tested in index order, the need test ahead of the free test.
    req_hit    = 1'b0;
    req_status = STS_GRANTED;
    for (int r = 0; r < NR; r++) begin
      if (!req_hit) begin
        if (EXT_W'(req_lane[r]) > EXT_W'(need_row[r])) begin
          req_hit    = 1'b1;
          req_status = STS_EXCEEDS;
        end else if (EXT_W'(req_lane[r]) > EXT_W'(free_vec[r])) begin
          req_hit    = 1'b1;
          req_status = STS_WAIT;
        end
      end
    end
  end

  always_comb begin
    store_cmd = '0;
    unique case (state)
      ST_EXEC: begin
        store_cmd.load_free = (mode_q == MODE_LOAD_FREE) && free_ok;
        store_cmd.load_pair = (mode_q == MODE_LOAD_PAIR) && pair_ok;
      end
      ST_GRANT:    store_cmd.grant = 1'b1;
      ST_ROLLBACK: store_cmd.undo = 1'b1;
      default: ;
    endcase
  end

  assign rd_pid = scan_running ? scan_pid : process_id_q[PID_W-1:0];

  bsa_store #(
    .NP(NP), .NR(NR), .CW(CW), .PID_W(PID_W), .RID_W(RID_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .cmd      (store_cmd),
    .pid      (rd_pid),
    .rid      (resource_id_q[RID_W-1:0]),
    .wr_value (CW'(amount_q)),
    .wr_need  (CW'(claim_q - amount_q)),
    .req      (req_vec),
    .free_vec (free_vec),
    .held_row (held_row),
    .need_row (need_row)
  );

  bsa_scan_unit #(
    .NP(NP), .NR(NR), .CW(CW), .PID_W(PID_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .go       (state == ST_SCAN_GO),
    .free_vec (free_vec),
    .need_row (need_row),
    .held_row (held_row),
    .rd_pid   (scan_pid),
    .running  (scan_running),
    .fin      (scan_fin),
    .safe     (scan_safe),
    .placed   (scan_placed),
    .order    (scan_order)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            mode_q        <= mode_t'(mode);
            process_id_q  <= process_id;
            resource_id_q <= resource_id;
            amount_q      <= amount;
            claim_q       <= claim;
            request_a_q   <= request_a;
            request_b_q   <= request_b;
            request_c_q   <= request_c;
            state         <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (mode_q)
            MODE_LOAD_FREE: begin
              done          <= 1'b1;
              status        <= free_ok ? STS_LOADED : STS_REJECTED;
              safe_count    <= '0;
              safe_sequence <= '0;
              state         <= ST_IDLE;
            end
            MODE_LOAD_PAIR: begin
              done          <= 1'b1;
              status        <= pair_ok ? STS_LOADED : STS_REJECTED;
              safe_count    <= '0;
              safe_sequence <= '0;
              state         <= ST_IDLE;
            end
            MODE_REQUEST: begin
              if (!pid_ok || req_hit) begin
                done          <= 1'b1;
                status        <= pid_ok ? req_status : STS_EXCEEDS;
                safe_count    <= '0;
                safe_sequence <= '0;
                state         <= ST_IDLE;
              end else begin
                state <= ST_GRANT;
              end
            end
            MODE_CHECK: state <= ST_SCAN_GO;
          endcase
        end
        ST_GRANT:   state <= ST_SCAN_GO;
        ST_SCAN_GO: state <= ST_SCAN_WAIT;
        ST_SCAN_WAIT: begin
          if (scan_fin) begin
            safe_count    <= scan_placed;
            safe_sequence <= scan_order;
            if (mode_q == MODE_CHECK) begin
              done   <= 1'b1;
              status <= scan_safe ? STS_SAFE : STS_UNSAFE;
              state  <= ST_IDLE;
            end else if (scan_safe) begin
              done   <= 1'b1;
              status <= STS_GRANTED;
              state  <= ST_IDLE;
            end else begin
              state <= ST_ROLLBACK;
            end
          end
        end
        ST_ROLLBACK: begin
          done   <= 1'b1;
          status <= STS_ROLLED_BACK;
          state  <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in progress");

  a_accept_enters_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_EXEC))
    else $error("command transfer did not start execution");

  a_fin_while_waiting: assert property (@(posedge clk) disable iff (rst)
    scan_fin |-> (state == ST_SCAN_WAIT))
    else $error("scan finished while the sequencer was not waiting for it");

  a_grant_only_request: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GRANT || state == ST_ROLLBACK) |-> (mode_q == MODE_REQUEST))
    else $error("table grant or undo outside a request");

  a_safe_count_full: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STS_SAFE || status == STS_GRANTED)) |->
      (safe_count == FULL_COUNT))
    else $error("safe result with processes left unplaced");
`endif

endmodule
